// ----- design/b32enc_pkg.sv -----
// Shared types, constants and the character table for the base32 text encoder.
package b32enc_pkg;

	localparam int GroupBits = 5;
	localparam int ByteBits  = 8;
	localparam int CharBits  = 7;
	localparam int PendBits  = 4;
	// left-aligned window: at most four leftover bits, one byte, padding to three groups
	localparam int WinBits   = 3 * GroupBits;
	localparam int MaxGroups = 3;

	// one message byte
	typedef struct packed {
		logic [ByteBits-1:0] data_byte;
		logic                last_byte;
	} byte_req_t;

	// one output character
	typedef struct packed {
		logic [CharBits-1:0]  text_char;
		logic [GroupBits-1:0] group_value;
		logic                 run_end;
		logic                 text_end;
	} char_req_t;

	// group value to ASCII; the alphabet skips 0, 1, I and O
	function automatic logic [CharBits-1:0] enc_char(input logic [GroupBits-1:0] v);
		logic [CharBits-1:0] vx;
		logic [CharBits-1:0] res;
		vx = CharBits'(v);
		if (v < 5'd8)
			res = vx + 7'd50;      // '2'..'9'
		else if (v < 5'd16)
			res = vx + 7'd57;      // 'A'..'H'
		else if (v < 5'd21)
			res = vx + 7'd58;      // 'J'..'N'
		else
			res = vx + 7'd59;      // 'P'..'Z'
		return res;
	endfunction

endpackage

// ----- design/bytes_to_base32_text_encoder_core.sv -----
// Top level of the base32 text encoder: byte stage, group buffer and character register.
//
//  channel   | role   | handshake             | payload
//  ----------+--------+-----------------------+---------------------------------
//  byte_*    | input  | byte_valid/byte_stall | byte_req  (data_byte, last_byte)
//  char_*    | output | char_valid/char_stall | char_req  (char, group, ends)
//
// A byte is split into its groups in the cycle it is accepted; the groups then
// leave one per cycle, while the character side does not stall, through the single
// character register, one or two groups per byte (three when a final byte adds a
// padded group to two full ones).
// A result passes the group buffer and then the character register to reach char_req.
// arst_n clears the leftover bits, the group buffer valid and index, and the output valid.
// A stall on the character side holds the register and backs up into byte_stall.
module bytes_to_base32_text_encoder_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  b32enc_pkg::byte_req_t byte_req,
	output logic                  char_valid,
	input  logic                  char_stall,
	output b32enc_pkg::char_req_t char_req
);

	// leftover state
	logic [b32enc_pkg::PendBits-1:0] pend_bits_q;
	logic [2:0]                      pend_cnt_q;

	// group buffer
	logic                             valid_s1;
	logic [b32enc_pkg::GroupBits-1:0] grp_s1 [b32enc_pkg::MaxGroups];
	logic [1:0]                       num_s1;
	logic                             last_s1;
	logic [1:0]                       idx_q;

	// character register
	logic                  char_valid_q;
	b32enc_pkg::char_req_t char_q;

	// split logic
	logic [11:0]                        acc;
	logic [3:0]                         total;
	logic [3:0]                         shift;
	logic [b32enc_pkg::WinBits-1:0]     win;
	logic                               two_grp;
	logic [2:0]                         rem;
	logic [b32enc_pkg::PendBits-1:0]    rem_mask;
	logic [1:0]                         num;

	logic accept;
	logic out_free;
	logic emit;
	logic at_end;
	logic done_s1;

	// stream bits of this byte after the leftovers, shifted to the window top
	always_comb begin
		acc      = {pend_bits_q, byte_req.data_byte};
		total    = 4'(pend_cnt_q) + 4'd8;
		shift    = 4'(b32enc_pkg::WinBits) - total;
		win      = b32enc_pkg::WinBits'({3'b000, acc} << shift);
		two_grp  = (total >= 4'd10);
		rem      = two_grp ? 3'(total - 4'd10) : 3'(total - 4'd5);
		rem_mask = 4'((5'd1 << rem) - 5'd1);
		num      = two_grp ? 2'd2 : 2'd1;
		if (byte_req.last_byte && (rem != 3'd0))
			num = num + 2'd1;
	end

	// handshake
	always_comb begin
		out_free   = !char_valid_q || !char_stall;
		emit       = valid_s1 && out_free;
		at_end     = (idx_q == (num_s1 - 2'd1));
		done_s1    = emit && at_end;
		byte_stall = valid_s1 && !done_s1;
		accept     = byte_valid && !byte_stall;
	end

	// leftover bits; a final byte starts the next message afresh
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (accept) begin
			if (byte_req.last_byte) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else begin
				pend_bits_q <= acc[b32enc_pkg::PendBits-1:0] & rem_mask;
				pend_cnt_q  <= rem;
			end
		end
	end

	// group buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// group buffer payload
	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1[0] <= win[14:10];
			grp_s1[1] <= win[9:5];
			grp_s1[2] <= win[4:0];
			num_s1    <= num;
			last_s1   <= byte_req.last_byte;
		end
	end

	// character register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			char_valid_q <= 1'b0;
		else if (out_free)
			char_valid_q <= valid_s1;
	end

	// character register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			char_q.text_char   <= b32enc_pkg::enc_char(grp_s1[idx_q]);
			char_q.group_value <= grp_s1[idx_q];
			char_q.run_end     <= at_end;
			char_q.text_end    <= at_end && last_s1;
		end
	end

	assign char_valid = char_valid_q;
	assign char_req   = char_q;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the base32 text encoder core: directed table, random messages.
module tb;

	localparam int NumItems   = 420;
	localparam int QuietFrom  = 360;  // no idling on either side from here on
	localparam int IdleLimit  = 1000; // cycles without any request before giving up
	localparam int TailCycles = 16;
	// character for group value v sits at [8*(31-v) +: 8]
	localparam logic [8*32-1:0] Alphabet = "23456789ABCDEFGHJKLMNPQRSTUVWXYZ";

	typedef struct {
		b32enc_pkg::byte_req_t req;
		string                 chars; // expected text, empty where the predictor decides
	} dir_row_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_stall;
	b32enc_pkg::byte_req_t byte_req   = '0;
	logic                  char_valid;
	logic                  char_stall = 1'b0;
	b32enc_pkg::char_req_t char_req;

	// predictor state: leftover bits of the message so far
	logic [b32enc_pkg::PendBits-1:0] pend_bits = '0;
	int                              pend_cnt  = 0;
	b32enc_pkg::char_req_t           chars_due[$];
	b32enc_pkg::char_req_t           want;
	dir_row_t                        dir_rows[$];
	int                              err_cnt   = 0;
	int                              n_sent    = 0;
	int                              idle_cycles = 0;
	bit                              quiet     = 1'b0;

	bytes_to_base32_text_encoder_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_req   (char_req)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		err_cnt++;
		$display("ERROR: char request %s", what);
	endtask

	// split one byte into its groups and queue the characters they give
	function automatic void encode_byte(input b32enc_pkg::byte_req_t r, input string typed);
		logic [11:0]           acc;
		int                    cnt;
		logic [4:0]            grp[$];
		b32enc_pkg::char_req_t c;
		acc = {pend_bits, r.data_byte};
		cnt = pend_cnt + 8;
		while (cnt >= b32enc_pkg::GroupBits) begin
			cnt -= b32enc_pkg::GroupBits;
			grp.push_back(5'(acc >> cnt));
		end
		acc &= (12'd1 << cnt) - 12'd1;
		// zero padding to a whole group on the final byte
		if (r.last_byte && cnt > 0)
			grp.push_back(5'(acc << (b32enc_pkg::GroupBits - cnt)));
		if (r.last_byte) begin
			acc = '0;
			cnt = 0;
		end
		pend_bits = acc[b32enc_pkg::PendBits-1:0];
		pend_cnt  = cnt;
		// a typed row overrides with the text read off by hand
		if (typed.len() != 0) begin
			grp.delete();
			for (int i = 0; i < typed.len(); i++)
				for (int v = 0; v < 32; v++)
					if (Alphabet[8*(31-v) +: 8] == typed[i])
						grp.push_back(5'(v));
		end
		for (int i = 0; i < grp.size(); i++) begin
			c.group_value = grp[i];
			c.text_char   = 7'(Alphabet[8*(31-grp[i]) +: 8]);
			c.run_end     = (i == grp.size() - 1);
			c.text_end    = r.last_byte && (i == grp.size() - 1);
			chars_due.push_back(c);
		end
	endfunction

	// present one byte, with an occasional idle burst first; returns once accepted
	task automatic send_byte(input b32enc_pkg::byte_req_t r, input string typed);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_req   <= r;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		encode_byte(r, typed);
		n_sent++;
	endtask

	task automatic drain_chars();
		byte_valid <= 1'b0;
		while (chars_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(input logic [7:0] d, input logic l, input string s);
		dir_row_t row;
		row.req.data_byte = d;
		row.req.last_byte = l;
		row.chars         = s;
		dir_rows.push_back(row);
	endtask

	// receiver: stall in random bursts until the quiet part
	initial begin
		int burst;
		@(posedge clk);
		forever begin
			burst = $urandom_range(1, 8);
			char_stall <= !quiet && ($urandom_range(0, 2) == 0);
			repeat (burst) @(posedge clk);
		end
	end

	// character checker
	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			if (chars_due.size() == 0) begin
				report_mismatch($sformatf("'%c' with none expected", char_req.text_char));
			end else begin
				want = chars_due.pop_front();
				if (char_req.text_char !== want.text_char)
					report_mismatch($sformatf("text_char %0d, expected %0d",
						char_req.text_char, want.text_char));
				if (char_req.group_value !== want.group_value)
					report_mismatch($sformatf("group_value %0d, expected %0d",
						char_req.group_value, want.group_value));
				if (char_req.run_end !== want.run_end)
					report_mismatch($sformatf("run_end %b, expected %b",
						char_req.run_end, want.run_end));
				if (char_req.text_end !== want.text_end)
					report_mismatch($sformatf("text_end %b, expected %b",
						char_req.text_end, want.text_end));
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("ERROR: no progress for %0d cycles, %0d chars outstanding",
				idle_cycles, chars_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		b32enc_pkg::byte_req_t r;
		int                    msg_len;
		bit                    drained;
		drained = 1'b0;

		// single-byte messages at the extremes
		add_row(8'h00, 1'b1, "22");
		add_row(8'hFF, 1'b1, "ZW");
		add_row(8'h80, 1'b1, "J2");
		add_row(8'h01, 1'b1, "26");
		// five bytes fill whole groups: no padding group at the end
		add_row(8'hFF, 1'b0, "Z");
		add_row(8'hFF, 1'b0, "ZZ");
		add_row(8'hFF, 1'b0, "Z");
		add_row(8'hFF, 1'b0, "ZZ");
		add_row(8'hFF, 1'b1, "ZZ");
		add_row(8'h00, 1'b0, "2");
		add_row(8'h00, 1'b0, "22");
		add_row(8'h00, 1'b0, "2");
		add_row(8'h00, 1'b0, "22");
		add_row(8'h00, 1'b1, "22");
		// four leftover bits into a final byte: three characters
		add_row(8'h12, 1'b0, "");
		add_row(8'h34, 1'b0, "");
		add_row(8'h56, 1'b0, "");
		add_row(8'h78, 1'b1, "");
		// padding from one, from four and from three leftover bits
		add_row(8'hA5, 1'b0, "");
		add_row(8'h5A, 1'b1, "");
		add_row(8'hC3, 1'b0, "");
		add_row(8'h3C, 1'b0, "");
		add_row(8'hE7, 1'b1, "");
		add_row(8'hAA, 1'b1, "");

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].req, dir_rows[i].chars);
		drain_chars();

		// random messages, mostly short, now and then long
		while (n_sent < NumItems) begin
			if ($urandom_range(0, 4) == 0)
				msg_len = $urandom_range(7, 24);
			else
				msg_len = $urandom_range(1, 6);
			for (int k = 0; k < msg_len; k++) begin
				if ($urandom_range(0, 7) == 0)
					r.data_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else
					r.data_byte = 8'($urandom);
				r.last_byte = (k == msg_len - 1);
				send_byte(r, "");
			end
			if (n_sent >= QuietFrom)
				quiet = 1'b1;
			if (!drained && n_sent >= NumItems / 2) begin
				drain_chars();
				drained = 1'b1;
			end
		end

		drain_chars();
		repeat (TailCycles) @(posedge clk);
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
